// File: rtl/izs_pkg.sv
// ----------------------------------------------------------------------------
// Irrigation zone scheduler package
// Shared types, command codes, state encoding and small helper functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package izs_pkg;

  localparam logic [30:0] SANE_SECONDS = 31'd1420070400;
  localparam logic [16:0] DAY_SECONDS  = 17'd86400;
  localparam logic [6:0]  RESET_ZONE   = 7'd100;
  localparam logic [6:0]  ALL_OFF_ZONE = 7'd101;
  localparam logic [6:0]  STEP_LIMIT   = 7'd100;

  // Reciprocal of 675 scaled by 2^35; exact for dividends below 2^25.
  localparam logic [25:0] DAY_RECIP    = 26'd50903317;

  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_MANUAL = 3'd1,
    CMD_CLEAR  = 3'd2,
    CMD_APPEND = 3'd3,
    CMD_COMMIT = 3'd4
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_FIRE_RD,
    ST_FIRE_EXEC,
    ST_RC_INIT,
    ST_RC_RD,
    ST_RC_LOAD,
    ST_RC_DIV,
    ST_RC_T0,
    ST_RC_STEP,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [30:0] now;
    logic [6:0]  zone;
    logic        on_off;
    logic [30:0] start_time;
    logic [30:0] end_time;
    logic [16:0] time_of_day;
    logic [15:0] duration;
    logic [7:0]  repeat_days;
    logic [6:0]  day_mask;
  } req_t;

  typedef struct packed {
    logic [7:0] relay_pattern;
    logic       reset_request;
    logic [5:0] pending_count;
    logic       table_full;
  } rsp_t;

  typedef struct packed {
    logic [30:0] start_time;
    logic [30:0] end_time;
    logic [6:0]  zone;
    logic [16:0] time_of_day;
    logic [15:0] duration;
    logic [7:0]  repeat_days;
    logic [6:0]  day_mask;
  } sched_ent_t;

  typedef struct packed {
    logic [30:0] on_time;
    logic [6:0]  zone;
    logic [15:0] duration;
  } pend_ent_t;

  typedef struct packed {
    logic latch;
    logic set_synced;
    logic countdown;
    logic manual;
    logic clear;
    logic append;
    logic fire_rd;
    logic fire_exec;
    logic rc_init;
    logic rc_rd;
    logic rc_load;
    logic rc_div;
    logic rc_t0;
    logic rc_step;
  } ctrl_t;

  typedef struct packed {
    logic cmd_tick;
    logic cmd_manual;
    logic cmd_clear;
    logic cmd_append;
    logic cmd_commit;
    logic synced;
    logic now_gt_sane;
    logic now_sane;
    logic fire_more;
    logic fired;
    logic rc_more;
    logic div_last;
    logic step_adv;
  } stat_t;

  function automatic logic [2:0] mod7_u8(input logic [7:0] x);
    logic [4:0] s1;
    logic [3:0] s2;
    s1 = {3'b0, x[7:6]} + {2'b0, x[5:3]} + {2'b0, x[2:0]};
    s2 = {2'b0, s1[4:3]} + {1'b0, s1[2:0]};
    if (s2 >= 4'd7) begin
      s2 = s2 - 4'd7;
    end
    return s2[2:0];
  endfunction

  function automatic logic [2:0] mod7_u16(input logic [15:0] x);
    logic [2:0] hi;
    logic [2:0] lo;
    hi = mod7_u8(x[15:8]);
    lo = mod7_u8(x[7:0]);
    return mod7_u8({3'b000, hi, 2'b00} + {5'b00000, lo});
  endfunction

  function automatic logic [2:0] mod7_small(input logic [3:0] x);
    logic [3:0] r;
    r = x;
    if (r >= 4'd7) begin
      r = r - 4'd7;
    end
    return r[2:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/izs_ctrl.sv
// ----------------------------------------------------------------------------
// Irrigation zone scheduler controller
// Sequences each request through dispatch, firing and recompute steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module izs_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire izs_pkg::stat_t stat_i,
  output izs_pkg::ctrl_t      ctrl_o,
  output logic                busy_o,
  output logic                done_o
);

  izs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= izs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      izs_pkg::ST_IDLE: begin
        if (start_i) state_d = izs_pkg::ST_DISPATCH;
      end
      izs_pkg::ST_DISPATCH: begin
        priority if (stat_i.cmd_tick) begin
          if (stat_i.synced) state_d = izs_pkg::ST_FIRE_RD;
          else if (stat_i.now_gt_sane) state_d = izs_pkg::ST_RC_INIT;
          else state_d = izs_pkg::ST_DONE;
        end else if (stat_i.cmd_commit) begin
          state_d = izs_pkg::ST_RC_INIT;
        end else begin
          state_d = izs_pkg::ST_DONE;
        end
      end
      izs_pkg::ST_FIRE_RD: begin
        if (stat_i.fire_more) state_d = izs_pkg::ST_FIRE_EXEC;
        else if (stat_i.fired) state_d = izs_pkg::ST_RC_INIT;
        else state_d = izs_pkg::ST_DONE;
      end
      izs_pkg::ST_FIRE_EXEC: state_d = izs_pkg::ST_FIRE_RD;
      izs_pkg::ST_RC_INIT: begin
        state_d = stat_i.now_sane ? izs_pkg::ST_RC_RD : izs_pkg::ST_DONE;
      end
      izs_pkg::ST_RC_RD: begin
        state_d = stat_i.rc_more ? izs_pkg::ST_RC_LOAD : izs_pkg::ST_DONE;
      end
      izs_pkg::ST_RC_LOAD: state_d = izs_pkg::ST_RC_DIV;
      izs_pkg::ST_RC_DIV: begin
        if (stat_i.div_last) state_d = izs_pkg::ST_RC_T0;
      end
      izs_pkg::ST_RC_T0: state_d = izs_pkg::ST_RC_STEP;
      izs_pkg::ST_RC_STEP: begin
        if (!stat_i.step_adv) state_d = izs_pkg::ST_RC_RD;
      end
      izs_pkg::ST_DONE: state_d = izs_pkg::ST_IDLE;
      default: state_d = izs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    busy_o = (state_q != izs_pkg::ST_IDLE);
    done_o = (state_q == izs_pkg::ST_DONE);
    unique case (state_q)
      izs_pkg::ST_IDLE: ctrl_o.latch = start_i;
      izs_pkg::ST_DISPATCH: begin
        ctrl_o.set_synced = stat_i.cmd_tick && !stat_i.synced && stat_i.now_gt_sane;
        ctrl_o.countdown  = stat_i.cmd_tick && stat_i.synced;
        ctrl_o.manual     = stat_i.cmd_manual;
        ctrl_o.clear      = stat_i.cmd_clear;
        ctrl_o.append     = stat_i.cmd_append;
      end
      izs_pkg::ST_FIRE_RD:   ctrl_o.fire_rd   = stat_i.fire_more;
      izs_pkg::ST_FIRE_EXEC: ctrl_o.fire_exec = 1'b1;
      izs_pkg::ST_RC_INIT:   ctrl_o.rc_init   = 1'b1;
      izs_pkg::ST_RC_RD:     ctrl_o.rc_rd     = stat_i.rc_more;
      izs_pkg::ST_RC_LOAD:   ctrl_o.rc_load   = 1'b1;
      izs_pkg::ST_RC_DIV:    ctrl_o.rc_div    = 1'b1;
      izs_pkg::ST_RC_T0:     ctrl_o.rc_t0     = 1'b1;
      izs_pkg::ST_RC_STEP:   ctrl_o.rc_step   = 1'b1;
      izs_pkg::ST_DONE: ;
      default: ;
    endcase
  end

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted request did not make the block busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o)
    else $error("block stayed busy after its result");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe lasted more than one cycle");

endmodule

`default_nettype wire

// File: rtl/izs_dp.sv
// ----------------------------------------------------------------------------
// Irrigation zone scheduler datapath
// Relay and countdown state, schedule and pending memories, day arithmetic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module izs_dp #(
  parameter int unsigned SCHEDULE_DEPTH = 32,
  parameter int unsigned ZONE_COUNT     = 8
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire izs_pkg::req_t  req_i,
  input  wire logic           cfg_we_i,
  input  wire logic [16:0]    cfg_wdata_i,
  input  wire izs_pkg::ctrl_t ctrl_i,
  output izs_pkg::stat_t      stat_o,
  output izs_pkg::rsp_t       rsp_o
);

  localparam int unsigned CW = $clog2(SCHEDULE_DEPTH + 1);
  localparam int unsigned IW = (SCHEDULE_DEPTH > 1) ? $clog2(SCHEDULE_DEPTH) : 1;

  izs_pkg::req_t       req_q;
  logic signed [16:0]  offset_q;
  logic [7:0]          relay_q, relay_d;
  logic [15:0]         cd_q [ZONE_COUNT];
  logic [15:0]         cd_d [ZONE_COUNT];
  logic                synced_q;
  logic [CW-1:0]       sc_q, pt_q, idx_q;
  logic                fired_q, rstreq_q, full_q;

  izs_pkg::sched_ent_t sched_mem [SCHEDULE_DEPTH];
  izs_pkg::sched_ent_t sched_rd_q;
  izs_pkg::pend_ent_t  pend_mem [SCHEDULE_DEPTH];
  izs_pkg::pend_ent_t  pend_rd_q;

  logic [30:0]         base_q;
  logic [31:0]         lsum_q;
  logic [15:0]         quo_q;
  logic [16:0]         rem_q;
  logic [2:0]          m_q, wd_q, repm_q;
  logic                bitcnt_q;
  logic [24:0]         stepv_q;
  logic [34:0]         t_q;
  logic [6:0]          steps_q;

  logic                now_sane, now_gt_sane;
  logic [30:0]         now_c;
  logic                due;
  logic [30:0]         base_sel;
  logic [32:0]         l_sum;
  logic [50:0]         recip_prod;
  logic [32:0]         quo_day;
  logic                step_cond, step_limit, store_ok;
  logic [34:0]         t_start;
  logic                tod_carry;

  assign now_sane    = (req_q.now >= izs_pkg::SANE_SECONDS);
  assign now_gt_sane = (req_q.now > izs_pkg::SANE_SECONDS);
  assign now_c       = now_sane ? req_q.now : 31'd0;
  assign due         = (now_c >= pend_rd_q.on_time);

  assign base_sel = (sched_rd_q.start_time != 31'd0) ? sched_rd_q.start_time : now_c;
  assign l_sum    = {2'b00, base_sel} + {{16{offset_q[16]}}, offset_q} + 33'd86400;

  // 86400 is 128 * 675, so the quotient is (l_sum >> 7) / 675.
  assign recip_prod = 51'(lsum_q[31:7]) * 51'(izs_pkg::DAY_RECIP);
  assign quo_day    = 33'(quo_q) * 33'(izs_pkg::DAY_SECONDS);

  assign tod_carry = (sched_rd_q.time_of_day >= izs_pkg::DAY_SECONDS);
  assign t_start   = {4'b0000, base_q} - {18'd0, rem_q} + {18'd0, sched_rd_q.time_of_day};

  assign step_cond  = ($signed(t_q) <= $signed({4'b0000, now_c})) ||
                      !sched_rd_q.day_mask[wd_q];
  assign step_limit = (steps_q == izs_pkg::STEP_LIMIT);
  assign store_ok   = !((sched_rd_q.end_time != 31'd0) &&
                        ($signed(t_q) >= $signed({4'b0000, sched_rd_q.end_time}))) &&
                      !t_q[34] && (t_q[33:31] == 3'b000);

  always_comb begin
    stat_o             = '0;
    stat_o.cmd_tick    = (req_q.cmd == izs_pkg::CMD_TICK);
    stat_o.cmd_manual  = (req_q.cmd == izs_pkg::CMD_MANUAL);
    stat_o.cmd_clear   = (req_q.cmd == izs_pkg::CMD_CLEAR);
    stat_o.cmd_append  = (req_q.cmd == izs_pkg::CMD_APPEND);
    stat_o.cmd_commit  = (req_q.cmd == izs_pkg::CMD_COMMIT);
    stat_o.synced      = synced_q;
    stat_o.now_gt_sane = now_gt_sane;
    stat_o.now_sane    = now_sane;
    stat_o.fire_more   = (idx_q < pt_q);
    stat_o.fired       = fired_q;
    stat_o.rc_more     = (idx_q < sc_q);
    stat_o.div_last    = bitcnt_q;
    stat_o.step_adv    = step_cond && !step_limit;
  end

  always_comb begin
    relay_d = relay_q;
    cd_d    = cd_q;
    if (ctrl_i.countdown) begin
      for (int i = 0; i < ZONE_COUNT; i++) begin
        if (cd_q[i] != 16'd0) begin
          cd_d[i] = cd_q[i] - 16'd1;
          if (cd_q[i] == 16'd1) relay_d[i] = 1'b0;
        end
      end
    end
    if (ctrl_i.manual) begin
      for (int i = 0; i < ZONE_COUNT; i++) begin
        if (req_q.zone == 7'(i + 1)) begin
          cd_d[i]    = req_q.on_off ? req_q.duration : 16'd0;
          relay_d[i] = req_q.on_off;
        end
      end
    end
    if (ctrl_i.clear || (ctrl_i.fire_exec && due && pend_rd_q.zone == izs_pkg::ALL_OFF_ZONE))
    begin
      relay_d = 8'd0;
      for (int i = 0; i < ZONE_COUNT; i++) cd_d[i] = 16'd0;
    end else if (ctrl_i.fire_exec && due) begin
      for (int i = 0; i < ZONE_COUNT; i++) begin
        if (pend_rd_q.zone == 7'(i + 1)) begin
          cd_d[i]    = pend_rd_q.duration;
          relay_d[i] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      relay_q  <= '0;
      synced_q <= 1'b0;
      sc_q     <= '0;
      pt_q     <= '0;
      idx_q    <= '0;
      fired_q  <= 1'b0;
      rstreq_q <= 1'b0;
      full_q   <= 1'b0;
      for (int i = 0; i < ZONE_COUNT; i++) cd_q[i] <= '0;
    end else begin
      relay_q <= relay_d;
      cd_q    <= cd_d;
      if (cfg_we_i) offset_q <= cfg_wdata_i;
      if (ctrl_i.latch) begin
        rstreq_q <= 1'b0;
        full_q   <= 1'b0;
      end
      if (ctrl_i.set_synced) synced_q <= 1'b1;
      if (ctrl_i.countdown) begin
        idx_q   <= '0;
        fired_q <= 1'b0;
      end
      if (ctrl_i.clear) sc_q <= '0;
      if (ctrl_i.append) begin
        if (sc_q < CW'(SCHEDULE_DEPTH)) sc_q <= sc_q + CW'(1);
        else full_q <= 1'b1;
      end
      if (ctrl_i.fire_exec) begin
        idx_q <= idx_q + CW'(1);
        if (due) begin
          fired_q <= 1'b1;
          if (pend_rd_q.zone == izs_pkg::RESET_ZONE) rstreq_q <= 1'b1;
        end
      end
      if (ctrl_i.rc_init) begin
        pt_q  <= '0;
        idx_q <= '0;
      end
      if (ctrl_i.rc_step && !(step_cond && !step_limit)) begin
        idx_q <= idx_q + CW'(1);
        if (!step_cond && store_ok) pt_q <= pt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch) req_q <= req_i;
    if (ctrl_i.append && (sc_q < CW'(SCHEDULE_DEPTH))) begin
      sched_mem[sc_q[IW-1:0]] <= '{start_time:  req_q.start_time,
                                   end_time:    req_q.end_time,
                                   zone:        req_q.zone,
                                   time_of_day: req_q.time_of_day,
                                   duration:    req_q.duration,
                                   repeat_days: req_q.repeat_days,
                                   day_mask:    req_q.day_mask};
    end
    if (ctrl_i.rc_rd) sched_rd_q <= sched_mem[idx_q[IW-1:0]];
    if (ctrl_i.fire_rd) pend_rd_q <= pend_mem[idx_q[IW-1:0]];
    if (ctrl_i.rc_step && !step_cond && store_ok) begin
      pend_mem[pt_q[IW-1:0]] <= '{on_time:  t_q[30:0],
                                  zone:     sched_rd_q.zone,
                                  duration: sched_rd_q.duration};
    end
    if (ctrl_i.rc_load) begin
      base_q   <= base_sel;
      lsum_q   <= l_sum[31:0];
      bitcnt_q <= 1'b0;
      stepv_q  <= 25'({17'd0, sched_rd_q.repeat_days} * {8'd0, izs_pkg::DAY_SECONDS});
      repm_q   <= izs_pkg::mod7_u8(sched_rd_q.repeat_days);
    end
    if (ctrl_i.rc_div) begin
      if (!bitcnt_q) begin
        quo_q <= recip_prod[50:35];
      end else begin
        rem_q <= 17'(lsum_q - quo_day[31:0]);
        m_q   <= izs_pkg::mod7_u16(quo_q);
      end
      bitcnt_q <= 1'b1;
    end
    if (ctrl_i.rc_t0) begin
      t_q     <= t_start;
      wd_q    <= izs_pkg::mod7_small({1'b0, m_q} + 4'd3 + {3'd0, tod_carry});
      steps_q <= 7'd0;
    end
    if (ctrl_i.rc_step && step_cond && !step_limit) begin
      t_q     <= t_q + {10'd0, stepv_q};
      wd_q    <= izs_pkg::mod7_small({1'b0, wd_q} + {1'b0, repm_q});
      steps_q <= steps_q + 7'd1;
    end
  end

  always_comb begin
    rsp_o.relay_pattern = relay_q;
    rsp_o.reset_request = rstreq_q;
    rsp_o.pending_count = 6'(pt_q);
    rsp_o.table_full    = full_q;
  end

  a_sc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sc_q <= CW'(SCHEDULE_DEPTH)) && (pt_q <= CW'(SCHEDULE_DEPTH)))
    else $error("table or pending count beyond depth");

  a_cd_relay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cd_q[0] != 16'd0) |-> relay_q[0])
    else $error("zone counting down while its relay is off");

  a_wd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.rc_step |-> (wd_q < 3'd7))
    else $error("weekday out of range");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.rc_step |-> (pt_q <= idx_q))
    else $error("more pending times than entries walked");

endmodule

`default_nettype wire

// File: rtl/irrigation_zone_scheduler_top.sv
// ----------------------------------------------------------------------------
// Irrigation zone scheduler
// Eight-zone relay timer driven by tick, manual, table and commit requests.
//
//   Channel   Signals                          Handshake
//   request   req_i                            start, busy
//   result    rsp_o                            done_o, one cycle strobe
//   config    cfg_wdata_i (zone offset)        cfg_we_i
//
// A manual, clear or append request goes from start through dispatch to done_o.
// A recompute walks the table one entry at a time: each entry is read and its
// day division done, then its day steps follow one by one (at most 100).
// Firing reads and then executes each pending time in turn. The reset is
// asynchronous and clears the relays, counts and sync flag; no memory is
// cleared. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module irrigation_zone_scheduler_top #(
  parameter int unsigned SCHEDULE_DEPTH = 32,
  parameter int unsigned ZONE_COUNT     = 8
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire izs_pkg::req_t  req_i,
  output logic                done_o,
  output izs_pkg::rsp_t       rsp_o,
  input  wire logic           cfg_we_i,
  input  wire logic [16:0]    cfg_wdata_i
);

  izs_pkg::ctrl_t ctrl;
  izs_pkg::stat_t stat;

  izs_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .ctrl_o  (ctrl),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  izs_dp #(
    .SCHEDULE_DEPTH (SCHEDULE_DEPTH),
    .ZONE_COUNT     (ZONE_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .rsp_o       (rsp_o)
  );

endmodule

`default_nettype wire

// File: bench/irrigation_zone_scheduler_top_tb.sv
// ----------------------------------------------------------------------------
// Irrigation zone scheduler testbench
// Drives tick, manual, clear, append and commit requests with random gaps
// under several zone offsets and checks every result against a predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module irrigation_zone_scheduler_top_tb;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam longint SANE = 64'd1420070400;
  localparam longint DAY = 64'd86400;
  localparam longint TOP31 = 64'h7fffffff;

  typedef enum logic [1:0] {K_REQ, K_CFG, K_DRAIN} kind_e;

  typedef struct {
    kind_e         kind;
    izs_pkg::req_t req;
    logic [16:0]   offset;
    int            gap;
  } step_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  izs_pkg::req_t req_i = '0;
  logic          done_o;
  izs_pkg::rsp_t rsp_o;
  logic          cfg_we_i = 1'b0;
  logic [16:0]   cfg_wdata_i = '0;

  step_t         stim_q[$];
  izs_pkg::rsp_t expected_q[$];
  int    errors = 0;
  int    hold_cnt = 0;
  logic  taken = 1'b0;
  int    idle_cycles = 0;
  bit    burst = 1'b0;

  // Predictor state.
  longint        zone_off = 0;
  bit [7:0]      relays = '0;
  bit [15:0]     countdown [8];
  bit            synced = 1'b0;
  int            table_n = 0;
  izs_pkg::req_t table_e [32];
  int            pend_n = 0;
  longint        pend_time [32];
  bit [6:0]      pend_zone [32];
  bit [15:0]     pend_dur [32];

  irrigation_zone_scheduler_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic longint day_floor(longint a);
    longint q;
    q = a / DAY;
    if ((a % DAY) != 0 && a < 0) begin
      q--;
    end
    return q;
  endfunction

  function automatic bit [6:0] weekday_of(longint t);
    longint d;
    d = (day_floor(t + zone_off) - 3) % 7;
    if (d < 0) begin
      d += 7;
    end
    return 7'd1 << d;
  endfunction

  function automatic void set_zone(int z, bit on, bit [15:0] dur);
    if (z >= 1 && z <= 8) begin
      countdown[z-1] = on ? dur : 16'd0;
      relays[z-1] = on;
    end
  endfunction

  function automatic void relays_off();
    for (int z = 1; z <= 8; z++) begin
      set_zone(z, 1'b0, 16'd0);
    end
  endfunction

  function automatic void plan_on_times(longint now);
    longint t;
    longint base;
    int steps;
    pend_n = 0;
    if (now < SANE) begin
      return;
    end
    for (int i = 0; i < table_n; i++) begin
      base = (table_e[i].start_time != 0) ? longint'(table_e[i].start_time) : now;
      t = day_floor(base + zone_off) * DAY - zone_off + table_e[i].time_of_day;
      steps = 0;
      while (t <= now || (weekday_of(t) & table_e[i].day_mask) == 0) begin
        t += DAY * table_e[i].repeat_days;
        steps++;
        if (steps > 100) begin
          break;
        end
      end
      if (steps > 100) begin
        continue;
      end
      if (table_e[i].end_time != 0 && t >= table_e[i].end_time) begin
        continue;
      end
      if (t < 0 || t > TOP31) begin
        continue;
      end
      pend_time[pend_n] = t;
      pend_zone[pend_n] = table_e[i].zone;
      pend_dur[pend_n] = table_e[i].duration;
      pend_n++;
    end
  endfunction

  function automatic izs_pkg::rsp_t predict_result(izs_pkg::req_t r);
    izs_pkg::rsp_t o;
    longint        now;
    bit            fired;
    o = '0;
    fired = 1'b0;
    now = (r.now < SANE) ? 0 : longint'(r.now);
    case (r.cmd)
      izs_pkg::CMD_TICK: begin
        if (!synced) begin
          if (now > SANE) begin
            synced = 1'b1;
            plan_on_times(now);
          end
        end else begin
          for (int i = 0; i < 8; i++) begin
            if (countdown[i] != 0) begin
              countdown[i]--;
              if (countdown[i] == 0) begin
                relays[i] = 1'b0;
              end
            end
          end
          for (int i = 0; i < pend_n; i++) begin
            if (now >= pend_time[i]) begin
              fired = 1'b1;
              if (pend_zone[i] == izs_pkg::RESET_ZONE) begin
                o.reset_request = 1'b1;
              end else if (pend_zone[i] == izs_pkg::ALL_OFF_ZONE) begin
                relays_off();
              end else begin
                set_zone(pend_zone[i], 1'b1, pend_dur[i]);
              end
            end
          end
          if (fired) begin
            plan_on_times(now);
          end
        end
      end
      izs_pkg::CMD_MANUAL: begin
        set_zone(r.zone, r.on_off, r.duration);
      end
      izs_pkg::CMD_CLEAR: begin
        relays_off();
        table_n = 0;
      end
      izs_pkg::CMD_APPEND: begin
        if (table_n < 32) begin
          table_e[table_n] = r;
          table_n++;
        end else begin
          o.table_full = 1'b1;
        end
      end
      izs_pkg::CMD_COMMIT: begin
        plan_on_times(now);
      end
      default: begin
      end
    endcase
    o.relay_pattern = relays;
    o.pending_count = pend_n[5:0];
    return o;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Result monitor and predictor update.
  always @(posedge clk_i) begin
    izs_pkg::rsp_t e;
    if (rst_ni) begin
      if (cfg_we_i) begin
        zone_off = longint'($signed(cfg_wdata_i));
      end
      if (done_o) begin
        if (expected_q.size() == 0) begin
          $display("%0t ns: result with none expected, actual %p", $time, rsp_o);
          errors++;
        end else begin
          e = expected_q.pop_front();
          check_field("relay_pattern", e.relay_pattern, rsp_o.relay_pattern);
          check_field("reset_request", e.reset_request, rsp_o.reset_request);
          check_field("pending_count", e.pending_count, rsp_o.pending_count);
          check_field("table_full", e.table_full, rsp_o.table_full);
        end
      end
      taken <= start && !busy;
      if (start && !busy) begin
        expected_q.push_back(predict_result(req_i));
      end
      idle_cycles <= (done_o || (start && !busy)) ? 0 : idle_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Request driver.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        cfg_we_i <= 1'b0;
      end else if (start) begin
        if (taken) begin
          start <= 1'b0;
        end
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
      end else if (stim_q.size() != 0) begin
        if (stim_q[0].kind == K_REQ) begin
          req_i <= stim_q[0].req;
          start <= 1'b1;
          hold_cnt <= stim_q[0].gap;
          void'(stim_q.pop_front());
        end else if (expected_q.size() == 0 && !busy && !taken) begin
          if (stim_q[0].kind == K_CFG) begin
            cfg_we_i <= 1'b1;
            cfg_wdata_i <= stim_q[0].offset;
          end
          void'(stim_q.pop_front());
        end
      end
    end
  end

  task automatic push_req(izs_pkg::req_t r);
    step_t s;
    s.kind = K_REQ;
    s.req = r;
    s.offset = '0;
    s.gap = burst ? 0 : $urandom_range(0, 15);
    stim_q.push_back(s);
  endtask

  task automatic push_ctl(kind_e k, logic [16:0] off);
    step_t s;
    s.kind = k;
    s.req = '0;
    s.offset = off;
    s.gap = 0;
    stim_q.push_back(s);
  endtask

  function automatic izs_pkg::req_t noise_req();
    izs_pkg::req_t r;
    r = izs_pkg::req_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    r.time_of_day = $urandom_range(0, 86399);
    return r;
  endfunction

  task automatic push_tick(longint now);
    izs_pkg::req_t r;
    r = noise_req();
    r.cmd = izs_pkg::CMD_TICK;
    r.now = now[30:0];
    push_req(r);
  endtask

  task automatic push_entry(longint base);
    izs_pkg::req_t r;
    int            pick;
    r = noise_req();
    r.cmd = izs_pkg::CMD_APPEND;
    pick = $urandom_range(0, 9);
    r.zone = (pick < 7) ? 7'($urandom_range(1, 8)) :
             (pick == 7) ? izs_pkg::RESET_ZONE :
             (pick == 8) ? izs_pkg::ALL_OFF_ZONE : r.zone;
    r.start_time = ($urandom_range(0, 2) == 0) ? 31'd0 :
                   31'(base - $urandom_range(0, 300000) + $urandom_range(0, 200000));
    r.end_time = ($urandom_range(0, 3) != 0) ? 31'd0 :
                 31'(base + $urandom_range(0, 900000));
    r.duration = ($urandom_range(0, 7) == 0) ? r.duration : 16'($urandom_range(0, 6));
    r.repeat_days = ($urandom_range(0, 7) == 0) ? r.repeat_days : 8'($urandom_range(1, 3));
    if ($urandom_range(0, 7) != 0 && r.day_mask == 0) begin
      r.day_mask = 7'h7f;
    end
    push_req(r);
  endtask

  initial begin
    izs_pkg::req_t r;
    longint        base;
    logic [16:0]   offsets [5];
    int            entries;

    for (int i = 0; i < 8; i++) begin
      countdown[i] = '0;
    end
    offsets[0] = 17'd0;
    offsets[1] = 17'(-50400);
    offsets[2] = 17'd50400;
    offsets[3] = 17'($urandom_range(0, 100800) - 50400);
    offsets[4] = 17'($urandom_range(0, 100800) - 50400);

    // Directed part: unsynced ticks, manual extremes, odd commands, edge entries, commits, first sync.
    push_ctl(K_CFG, offsets[0]);
    r = '0;
    r.cmd = izs_pkg::CMD_TICK;
    push_req(r);
    r.now = SANE[30:0];
    push_req(r);
    r.cmd = izs_pkg::CMD_MANUAL;
    r.zone = 7'd1;
    r.on_off = 1'b1;
    r.duration = 16'd0;
    push_req(r);
    r.zone = 7'd8;
    r.duration = 16'hffff;
    push_req(r);
    r.zone = 7'd0;
    push_req(r);
    r.zone = 7'd127;
    push_req(r);
    r.zone = 7'd1;
    r.on_off = 1'b0;
    push_req(r);
    for (int c = 5; c < 8; c++) begin
      r = noise_req();
      r.cmd = 3'(c);
      push_req(r);
    end
    r = '0;
    r.cmd = izs_pkg::CMD_APPEND;
    r.zone = 7'd2;
    r.start_time = 31'h7fffffff;
    r.time_of_day = 17'd86399;
    r.duration = 16'hffff;
    r.repeat_days = 8'hff;
    r.day_mask = 7'h7f;
    push_req(r);
    r.start_time = 31'd0;
    r.day_mask = 7'd0;
    r.repeat_days = 8'd1;
    push_req(r);
    r.repeat_days = 8'd0;
    r.day_mask = 7'h01;
    push_req(r);
    r.zone = 7'd3;
    r.repeat_days = 8'd1;
    r.end_time = 31'd1;
    push_req(r);
    r.cmd = izs_pkg::CMD_COMMIT;
    r.now = 31'd1000;
    push_req(r);
    push_tick(SANE + 1);
    push_tick(SANE + 90000);
    r.cmd = izs_pkg::CMD_COMMIT;
    r.now = 31'h7fffffff;
    push_req(r);
    r.cmd = izs_pkg::CMD_CLEAR;
    push_req(r);
    push_ctl(K_DRAIN, '0);

    // Random phases: clear, fill the table, commit, then walk time forward with stray requests.
    for (int p = 0; p < 5; p++) begin
      push_ctl(K_CFG, offsets[p]);
      burst = (p == 2);
      base = 64'd1500000000 + $urandom_range(0, 600000000);
      r = noise_req();
      r.cmd = izs_pkg::CMD_CLEAR;
      push_req(r);
      entries = (p == 3) ? 34 : $urandom_range(3, 8);
      for (int i = 0; i < entries; i++) begin
        push_entry(base);
      end
      r = noise_req();
      r.cmd = izs_pkg::CMD_COMMIT;
      r.now = base[30:0];
      push_req(r);
      for (int i = 0; i < 12; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          r = noise_req();
          r.cmd = ($urandom_range(0, 1) == 0) ? izs_pkg::CMD_MANUAL : izs_pkg::CMD_COMMIT;
          if ($urandom_range(0, 1) == 0) begin
            r.zone = 7'($urandom_range(1, 8));
            r.duration = 16'($urandom_range(0, 5));
          end
          r.now = base[30:0];
          push_req(r);
        end else if ($urandom_range(0, 12) == 0) begin
          push_tick($urandom_range(0, 1000));
        end else begin
          base += ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) :
                  $urandom_range(1, 40000);
          push_tick(base);
        end
      end
      push_ctl(K_DRAIN, '0);
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (stim_q.size() != 0 || expected_q.size() != 0 || start) begin
      @(posedge clk_i);
    end
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
